// ----- hdl/bbmm_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor mixer package
// Shared types, register map and fixed constants of the balance controller.
// ----------------------------------------------------------------------------
package bbmm_pkg;

    localparam int DATA_W     = 16;
    localparam int ANGLE_W    = 13;
    localparam int PERIOD_W   = 5;
    localparam int INTEG_W    = 9;
    localparam int TURN_W     = 11;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Half and full turn in sixteenths of a degree.
    localparam logic signed [13:0] HALF_TURN_Q4 = 14'sd2880;
    localparam logic signed [13:0] FULL_TURN_Q4 = 14'sd5760;

    // Register map, one word per register.
    typedef enum logic [2:0] {
        REG_VEL_PGAIN  = 3'd0,
        REG_VEL_IGAIN  = 3'd1,
        REG_HEADING_KP = 3'd2,
        REG_TURN_KP    = 3'd3,
        REG_TILT_KP    = 3'd4,
        REG_TILT_KD    = 3'd5,
        REG_CENTRE     = 3'd6,
        REG_GYRO_BIAS  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        TURN_RATE    = 2'd0,
        TURN_HEADING = 2'd1,
        TURN_HOLD    = 2'd2
    } t_turn_mode;

    localparam logic signed [15:0] RST_VEL_PGAIN  = 16'sd2560;
    localparam logic signed [15:0] RST_VEL_IGAIN  = 16'sd256;
    localparam logic signed [15:0] RST_HEADING_KP = 16'sd2560;
    localparam logic signed [15:0] RST_TURN_KP    = 16'sd2560;
    localparam logic signed [15:0] RST_TILT_KP    = 16'sd23040;
    localparam logic signed [15:0] RST_TILT_KD    = 16'sd256;
    localparam logic signed [12:0] RST_CENTRE     = -13'sd96;
    localparam logic signed [15:0] RST_GYRO_BIAS  = 16'sd53;

    typedef struct packed {
        logic signed [15:0] vel_pgain;
        logic signed [15:0] vel_igain;
        logic signed [15:0] heading_kp;
        logic signed [15:0] turn_kp;
        logic signed [15:0] tilt_kp;
        logic signed [15:0] tilt_kd;
        logic signed [12:0] centre;
        logic signed [15:0] gyro_bias;
    } t_cfg;

    // One control tick as captured at the input.
    typedef struct packed {
        logic signed [12:0] roll_angle;
        logic signed [15:0] pitch_rate;
        logic signed [12:0] yaw_angle;
        logic signed [12:0] heading_target;
        logic signed [15:0] turn_rate_target;
        logic [1:0]         turn_mode;
        logic signed [15:0] fwd_demand;
        logic signed [15:0] wheel_speed_sum;
        logic               run_enable;
    } t_tick;

    // Products and control flags handed from the multiply stage to the mix stage.
    typedef struct packed {
        logic               run;
        logic signed [29:0] tilt_p;
        logic signed [32:0] tilt_d;
        logic signed [32:0] turn_prod;
        logic               turn_heading;
        logic               turn_update;
        logic               speed_fire;
        logic signed [32:0] speed_p;
        logic signed [24:0] speed_i;
    } t_prod;

endpackage

// ----- hdl/bbmm_regs.sv -----
// ----------------------------------------------------------------------------
// Motor mixer configuration registers
// APB-style register file holding the loop gains, centre angle and gyro bias.
// ----------------------------------------------------------------------------
module bbmm_regs
    import bbmm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vel_pgain  <= RST_VEL_PGAIN;
            r_cfg.vel_igain  <= RST_VEL_IGAIN;
            r_cfg.heading_kp <= RST_HEADING_KP;
            r_cfg.turn_kp    <= RST_TURN_KP;
            r_cfg.tilt_kp    <= RST_TILT_KP;
            r_cfg.tilt_kd    <= RST_TILT_KD;
            r_cfg.centre     <= RST_CENTRE;
            r_cfg.gyro_bias  <= RST_GYRO_BIAS;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_VEL_PGAIN:  r_cfg.vel_pgain  <= pwdata[15:0];
                REG_VEL_IGAIN:  r_cfg.vel_igain  <= pwdata[15:0];
                REG_HEADING_KP: r_cfg.heading_kp <= pwdata[15:0];
                REG_TURN_KP:    r_cfg.turn_kp    <= pwdata[15:0];
                REG_TILT_KP:    r_cfg.tilt_kp    <= pwdata[15:0];
                REG_TILT_KD:    r_cfg.tilt_kd    <= pwdata[15:0];
                REG_CENTRE:     r_cfg.centre     <= pwdata[12:0];
                REG_GYRO_BIAS:  r_cfg.gyro_bias  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Reads return the register sign-extended to the bus width.
    always_comb begin
        case (reg_idx)
            REG_VEL_PGAIN:  prdata = {{16{r_cfg.vel_pgain[15]}}, r_cfg.vel_pgain};
            REG_VEL_IGAIN:  prdata = {{16{r_cfg.vel_igain[15]}}, r_cfg.vel_igain};
            REG_HEADING_KP: prdata = {{16{r_cfg.heading_kp[15]}}, r_cfg.heading_kp};
            REG_TURN_KP:    prdata = {{16{r_cfg.turn_kp[15]}}, r_cfg.turn_kp};
            REG_TILT_KP:    prdata = {{16{r_cfg.tilt_kp[15]}}, r_cfg.tilt_kp};
            REG_TILT_KD:    prdata = {{16{r_cfg.tilt_kd[15]}}, r_cfg.tilt_kd};
            REG_CENTRE:     prdata = {{19{r_cfg.centre[12]}}, r_cfg.centre};
            REG_GYRO_BIAS:  prdata = {{16{r_cfg.gyro_bias[15]}}, r_cfg.gyro_bias};
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- hdl/bbmm_terms.sv -----
// ----------------------------------------------------------------------------
// Motor mixer multiply stage
// Forms the tilt, turn and speed products of one tick and keeps the speed
// loop's period counter and integral.
// ----------------------------------------------------------------------------
module bbmm_terms
    import bbmm_pkg::*;
#(
    parameter int SPEED_PERIOD   = 20,
    parameter int INTEGRAL_LIMIT = 150
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_tick i_tick,
    output logic  o_ready,
    input  logic  i_dn_ready,
    output logic  o_valid,
    output t_prod o_prod
);

    localparam logic [PERIOD_W-1:0] PERIOD_END = PERIOD_W'(SPEED_PERIOD);
    localparam logic signed [17:0]  ILIM       = 18'(INTEGRAL_LIMIT);

    logic                       r_valid;
    t_prod                      r_prod;
    logic [PERIOD_W-1:0]        r_period;
    logic signed [INTEG_W-1:0]  r_integ;

    t_prod                      n_prod;
    logic [PERIOD_W-1:0]        n_period;
    logic signed [INTEG_W-1:0]  n_integ;

    logic                       take;
    logic signed [13:0]         roll_err;
    logic signed [16:0]         gyro;
    logic signed [13:0]         head_err;
    logic signed [13:0]         head_wrap;
    logic                       head_ok;
    logic signed [16:0]         turn_op;
    logic signed [15:0]         turn_gain;
    logic signed [16:0]         speed_err;
    logic signed [17:0]         integ_sum;
    logic signed [29:0]         tilt_p;
    logic signed [32:0]         tilt_d;
    logic signed [32:0]         turn_prod;
    logic signed [32:0]         speed_p;
    logic signed [24:0]         speed_i;

    assign o_ready = !r_valid || i_dn_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_comb begin
        roll_err = 14'(i_tick.roll_angle) - 14'(i_cfg.centre);
        gyro     = 17'(i_cfg.gyro_bias) - 17'(i_tick.pitch_rate);
        tilt_p   = roll_err * i_cfg.tilt_kp;
        tilt_d   = gyro * i_cfg.tilt_kd;

        // Heading error folded into the half-open range of plus or minus half a turn.
        head_err  = 14'(i_tick.yaw_angle) - 14'(i_tick.heading_target);
        head_ok   = 1'b1;
        head_wrap = head_err;
        if (head_err >= -FULL_TURN_Q4 && head_err < -HALF_TURN_Q4) begin
            head_wrap = head_err + FULL_TURN_Q4;
        end else if (head_err >= -HALF_TURN_Q4 && head_err < HALF_TURN_Q4) begin
            head_wrap = head_err;
        end else if (head_err >= HALF_TURN_Q4 && head_err <= FULL_TURN_Q4) begin
            head_wrap = head_err - FULL_TURN_Q4;
        end else begin
            head_ok = 1'b0;
        end

        n_prod.turn_heading = 1'b0;
        n_prod.turn_update  = 1'b0;
        turn_op             = 17'(i_tick.turn_rate_target);
        turn_gain           = i_cfg.turn_kp;
        case (t_turn_mode'(i_tick.turn_mode))
            TURN_RATE: begin
                n_prod.turn_update = i_tick.run_enable;
            end
            TURN_HEADING: begin
                turn_op             = 17'(head_wrap);
                turn_gain           = i_cfg.heading_kp;
                n_prod.turn_heading = 1'b1;
                n_prod.turn_update  = i_tick.run_enable && head_ok;
            end
            default: ;
        endcase
        turn_prod = turn_op * turn_gain;

        // Speed loop runs on the tick that brings the counter to the period.
        n_period  = r_period + PERIOD_W'(1);
        speed_err = 17'(i_tick.fwd_demand) - 17'(i_tick.wheel_speed_sum);
        integ_sum = 18'(r_integ) + 18'(speed_err);
        if (integ_sum > ILIM) begin
            n_integ = INTEG_W'(ILIM);
        end else if (integ_sum < -ILIM) begin
            n_integ = INTEG_W'(-ILIM);
        end else begin
            n_integ = INTEG_W'(integ_sum);
        end
        speed_p = speed_err * i_cfg.vel_pgain;
        speed_i = n_integ * i_cfg.vel_igain;

        n_prod.run        = i_tick.run_enable;
        n_prod.tilt_p     = tilt_p;
        n_prod.tilt_d     = tilt_d;
        n_prod.turn_prod  = turn_prod;
        n_prod.speed_fire = i_tick.run_enable && (n_period >= PERIOD_END);
        n_prod.speed_p    = speed_p;
        n_prod.speed_i    = speed_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_period <= '0;
            r_integ  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take && i_tick.run_enable) begin
                if (n_prod.speed_fire) begin
                    r_period <= '0;
                    r_integ  <= n_integ;
                end else begin
                    r_period <= n_period;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prod <= n_prod;
        end
    end

    a_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= INTEG_W'(ILIM)) && (r_integ >= INTEG_W'(-ILIM)))
        else $error("speed integral outside its limit");

    a_period_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period < PERIOD_END)
        else $error("period counter passed the speed period");

endmodule

// ----- hdl/bbmm_mix.sv -----
// ----------------------------------------------------------------------------
// Motor mixer output stage
// Scales and limits the three terms, keeps the held turn and speed terms and
// registers the two saturated motor drives.
// ----------------------------------------------------------------------------
module bbmm_mix
    import bbmm_pkg::*;
#(
    parameter int TURN_LIMIT = 500
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_prod                    i_prod,
    output logic                     o_ready,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_left_drive,
    output logic signed [DATA_W-1:0] o_right_drive
);

    localparam logic signed [33:0] TLIM = 34'(TURN_LIMIT);

    logic                      r_valid;
    logic signed [DATA_W-1:0]  r_left;
    logic signed [DATA_W-1:0]  r_right;
    logic signed [DATA_W-1:0]  r_speed_term;
    logic signed [TURN_W-1:0]  r_turn_term;

    logic signed [DATA_W-1:0]  n_left;
    logic signed [DATA_W-1:0]  n_right;
    logic signed [DATA_W-1:0]  n_speed_term;
    logic signed [TURN_W-1:0]  n_turn_term;

    logic                      take;
    logic signed [33:0]        tilt_acc;
    logic signed [33:0]        tilt_rnd;
    logic signed [DATA_W-1:0]  angle;
    logic signed [33:0]        turn_rnd;
    logic signed [33:0]        turn_scaled;
    logic signed [33:0]        speed_acc;
    logic signed [33:0]        speed_rnd;
    logic signed [DATA_W-1:0]  speed_use;
    logic signed [TURN_W-1:0]  turn_use;
    logic signed [33:0]        left_sum;
    logic signed [33:0]        right_sum;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [33:0] x);
        logic signed [DATA_W-1:0] y;
        if (x > 34'sd32767) begin
            y = 16'sh7FFF;
        end else if (x < -34'sd32768) begin
            y = 16'sh8000;
        end else begin
            y = x[DATA_W-1:0];
        end
        return y;
    endfunction

    assign o_ready       = !r_valid || !i_stall;
    assign take          = i_valid && o_ready;
    assign o_valid       = r_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;

    always_comb begin
        // Shifts round toward zero: negative sums get the shifted-out mask added first.
        tilt_acc = 34'(i_prod.tilt_p) + 34'(i_prod.tilt_d);
        tilt_rnd = tilt_acc + (tilt_acc[33] ? 34'sd4095 : 34'sd0);
        angle    = sat16(tilt_rnd >>> 12);

        if (i_prod.turn_heading) begin
            turn_rnd    = 34'(i_prod.turn_prod) + (i_prod.turn_prod[32] ? 34'sd4095 : 34'sd0);
            turn_scaled = turn_rnd >>> 12;
        end else begin
            turn_rnd    = 34'(i_prod.turn_prod) + (i_prod.turn_prod[32] ? 34'sd255 : 34'sd0);
            turn_scaled = turn_rnd >>> 8;
        end
        if (turn_scaled > TLIM) begin
            n_turn_term = TURN_W'(TLIM);
        end else if (turn_scaled < -TLIM) begin
            n_turn_term = TURN_W'(-TLIM);
        end else begin
            n_turn_term = TURN_W'(turn_scaled);
        end

        speed_acc    = 34'(i_prod.speed_p) + 34'(i_prod.speed_i);
        speed_rnd    = speed_acc + (speed_acc[33] ? 34'sd255 : 34'sd0);
        n_speed_term = sat16(speed_rnd >>> 8);

        speed_use = i_prod.speed_fire  ? n_speed_term : r_speed_term;
        turn_use  = i_prod.turn_update ? n_turn_term  : r_turn_term;

        left_sum  = 34'(angle) - 34'(speed_use) + 34'(turn_use);
        right_sum = 34'(angle) - 34'(speed_use) - 34'(turn_use);

        if (i_prod.run) begin
            n_left  = sat16(left_sum);
            n_right = sat16(right_sum);
        end else begin
            n_left  = '0;
            n_right = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_speed_term <= '0;
            r_turn_term  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take && i_prod.speed_fire) begin
                r_speed_term <= n_speed_term;
            end
            if (take && i_prod.turn_update) begin
                r_turn_term <= n_turn_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    a_turn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_turn_term <= TURN_W'(TLIM)) && (r_turn_term >= TURN_W'(-TLIM)))
        else $error("held turn term outside its limit");

    a_speed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(take && i_prod.speed_fire) |=> $stable(r_speed_term))
        else $error("speed term changed between speed loop runs");

endmodule

// ----- hdl/balance_robot_motor_mixer.sv -----
// ----------------------------------------------------------------------------
// Balance robot motor mixer
// Tilt PD, turn term and speed PI of a two-wheel balancing robot, mixed into
// left and right motor drives, one control tick per item.
//
//   Channel   Direction  Handshake           Payload
//   tick      in         i_valid / o_stall   roll, rates, targets, mode, run
//   drive     out        o_valid / i_stall   left and right drive
//   config    in         APB write and read  gains, centre angle, gyro bias
//
// An item can be taken every cycle while o_stall is low. Its drives pass through
// the input register, the product register and the output register in turn,
// as the multiplies are split from the rounding and mixing.
// Synchronous reset clears all valid flags and controller state and loads the
// register reset values.
// o_stall rises only when all three stages hold items and i_stall is high.
// ----------------------------------------------------------------------------
module balance_robot_motor_mixer
    import bbmm_pkg::*;
#(
    parameter int SPEED_PERIOD   = 20,
    parameter int INTEGRAL_LIMIT = 150,
    parameter int TURN_LIMIT     = 500
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [12:0]        i_roll_angle,
    input  logic signed [15:0]        i_pitch_rate,
    input  logic signed [12:0]        i_yaw_angle,
    input  logic signed [12:0]        i_heading_target,
    input  logic signed [15:0]        i_turn_rate_target,
    input  logic [1:0]                i_turn_mode,
    input  logic signed [15:0]        i_fwd_demand,
    input  logic signed [15:0]        i_wheel_speed_sum,
    input  logic                      i_run_enable,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DATA_W-1:0]  o_left_drive,
    output logic signed [DATA_W-1:0]  o_right_drive
);

    t_cfg   cfg;
    logic   r_in_valid;
    t_tick  r_tick;
    t_tick  n_tick;
    logic   in_ready;
    logic   terms_ready;
    logic   prod_valid;
    t_prod  prod;
    logic   mix_ready;

    assign in_ready = !r_in_valid || terms_ready;
    assign o_stall  = !in_ready;

    always_comb begin
        n_tick.roll_angle       = i_roll_angle;
        n_tick.pitch_rate       = i_pitch_rate;
        n_tick.yaw_angle        = i_yaw_angle;
        n_tick.heading_target   = i_heading_target;
        n_tick.turn_rate_target = i_turn_rate_target;
        n_tick.turn_mode        = i_turn_mode;
        n_tick.fwd_demand       = i_fwd_demand;
        n_tick.wheel_speed_sum  = i_wheel_speed_sum;
        n_tick.run_enable       = i_run_enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && in_ready) begin
            r_tick <= n_tick;
        end
    end

    bbmm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bbmm_terms #(
        .SPEED_PERIOD   (SPEED_PERIOD),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_terms (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (r_in_valid),
        .i_tick     (r_tick),
        .o_ready    (terms_ready),
        .i_dn_ready (mix_ready),
        .o_valid    (prod_valid),
        .o_prod     (prod)
    );

    bbmm_mix #(
        .TURN_LIMIT (TURN_LIMIT)
    ) u_mix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (prod_valid),
        .i_prod        (prod),
        .o_ready       (mix_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive)
    );

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while the output side was free");

endmodule

// ----- dv/balance_robot_motor_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// Balance robot motor mixer testbench
// Sends control ticks through the block under several gain settings and
// checks every left and right drive against a cycle-free model of the tilt
// PD, turn term and speed PI. The sender works in bursts and the receiver
// stalls on a changing pattern. Gains are changed over APB only while idle.
// ----------------------------------------------------------------------------
module balance_robot_motor_mixer_tb;
    import bbmm_pkg::*;

    localparam int SPEED_PERIOD    = 20;
    localparam int INTEGRAL_LIMIT  = 150;
    localparam int TURN_LIMIT      = 500;
    localparam int N_PHASES        = 8;
    localparam int TICKS_PER_PHASE = 225;
    localparam int MAX_PRINTED     = 40;
    localparam logic [1:0] TURN_SPARE = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BEAT
    } t_stall_style;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_drive_pair;

    typedef struct {
        t_tick              tk;
        bit                 typed;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_tick_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic signed [12:0]    i_roll_angle = '0;
    logic signed [15:0]    i_pitch_rate = '0;
    logic signed [12:0]    i_yaw_angle = '0;
    logic signed [12:0]    i_heading_target = '0;
    logic signed [15:0]    i_turn_rate_target = '0;
    logic [1:0]            i_turn_mode = '0;
    logic signed [15:0]    i_fwd_demand = '0;
    logic signed [15:0]    i_wheel_speed_sum = '0;
    logic                  i_run_enable = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic signed [15:0]    o_left_drive;
    logic signed [15:0]    o_right_drive;

    balance_robot_motor_mixer #(
        .SPEED_PERIOD   (SPEED_PERIOD),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .TURN_LIMIT     (TURN_LIMIT)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_roll_angle       (i_roll_angle),
        .i_pitch_rate       (i_pitch_rate),
        .i_yaw_angle        (i_yaw_angle),
        .i_heading_target   (i_heading_target),
        .i_turn_rate_target (i_turn_rate_target),
        .i_turn_mode        (i_turn_mode),
        .i_fwd_demand       (i_fwd_demand),
        .i_wheel_speed_sum  (i_wheel_speed_sum),
        .i_run_enable       (i_run_enable),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_left_drive       (o_left_drive),
        .o_right_drive      (o_right_drive)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the gain registers.
    longint g_vel_pgain = RST_VEL_PGAIN;
    longint g_vel_igain = RST_VEL_IGAIN;
    longint g_head_kp   = RST_HEADING_KP;
    longint g_turn_kp   = RST_TURN_KP;
    longint g_tilt_kp   = RST_TILT_KP;
    longint g_tilt_kd   = RST_TILT_KD;
    longint g_centre    = RST_CENTRE;
    longint g_bias      = RST_GYRO_BIAS;

    // Controller state as the block should hold it.
    int     period_cnt = 0;
    longint speed_integ = 0;
    longint speed_out = 0;
    longint turn_out = 0;

    t_drive_pair drives_due[$];
    t_tick_row   plan[$];

    int n_ticks = 0;
    int n_drives = 0;
    int n_errors = 0;
    int n_speed_runs = 0;
    int n_directed = 0;
    int burst_left = 0;

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // Works out the drives for one accepted tick and advances the controller state.
    function automatic void mixer_predict(input t_tick tk,
                                          output logic signed [15:0] left,
                                          output logic signed [15:0] right);
        longint roll, rate, yaw, head, tspd, fwd, wheel;
        longint acc, angle, d, e, l, r;
        roll  = tk.roll_angle;
        rate  = tk.pitch_rate;
        yaw   = tk.yaw_angle;
        head  = tk.heading_target;
        tspd  = tk.turn_rate_target;
        fwd   = tk.fwd_demand;
        wheel = tk.wheel_speed_sum;
        if (!tk.run_enable) begin
            left = '0;
            right = '0;
            return;
        end
        // Division truncates toward zero, as the fixed-point scaling asks.
        acc = g_tilt_kp * (roll - g_centre) + g_tilt_kd * (-(rate - g_bias));
        angle = clip(acc / 4096, -32768, 32767);

        if (tk.turn_mode == TURN_RATE) begin
            turn_out = clip((g_turn_kp * tspd) / 256, -TURN_LIMIT, TURN_LIMIT);
        end else if (tk.turn_mode == TURN_HEADING) begin
            d = yaw - head;
            // An error beyond a full turn either way leaves the turn term as it was.
            if (d >= -FULL_TURN_Q4 && d <= FULL_TURN_Q4) begin
                if (d < -HALF_TURN_Q4) d = d + FULL_TURN_Q4;
                else if (d >= HALF_TURN_Q4) d = d - FULL_TURN_Q4;
                turn_out = clip((g_head_kp * d) / 4096, -TURN_LIMIT, TURN_LIMIT);
            end
        end

        period_cnt = (period_cnt + 1) & 31;
        if (period_cnt >= SPEED_PERIOD) begin
            e = fwd - wheel;
            period_cnt = 0;
            speed_integ = clip(speed_integ + e, -INTEGRAL_LIMIT, INTEGRAL_LIMIT);
            speed_out = clip((e * g_vel_pgain + speed_integ * g_vel_igain) / 256,
                             -32768, 32767);
            n_speed_runs++;
        end

        l = clip(angle - speed_out + turn_out, -32768, 32767);
        r = clip(angle - speed_out - turn_out, -32768, 32767);
        left = 16'(l);
        right = 16'(r);
    endfunction

    task automatic report_miss(input string msg);
        if (n_errors < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
        n_errors++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        case (idx)
            REG_VEL_PGAIN:  g_vel_pgain = longint'($signed(16'(value)));
            REG_VEL_IGAIN:  g_vel_igain = longint'($signed(16'(value)));
            REG_HEADING_KP: g_head_kp   = longint'($signed(16'(value)));
            REG_TURN_KP:    g_turn_kp   = longint'($signed(16'(value)));
            REG_TILT_KP:    g_tilt_kp   = longint'($signed(16'(value)));
            REG_TILT_KD:    g_tilt_kd   = longint'($signed(16'(value)));
            REG_CENTRE:     g_centre    = longint'($signed(13'(value)));
            default:        g_bias      = longint'($signed(16'(value)));
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_gains(input int vel_pgain, input int vel_igain, input int head_kp,
                              input int turn_kp, input int tilt_kp, input int tilt_kd,
                              input int centre, input int bias);
        write_reg(REG_VEL_PGAIN, vel_pgain);
        write_reg(REG_VEL_IGAIN, vel_igain);
        write_reg(REG_HEADING_KP, head_kp);
        write_reg(REG_TURN_KP, turn_kp);
        write_reg(REG_TILT_KP, tilt_kp);
        write_reg(REG_TILT_KD, tilt_kd);
        write_reg(REG_CENTRE, centre);
        write_reg(REG_GYRO_BIAS, bias);
    endtask

    function automatic int rand_gain();
        case ($urandom_range(0, 5))
            0:       return 32767;
            1:       return -32768;
            2:       return int'($urandom_range(0, 2048)) - 1024;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic logic signed [15:0] pick_wide();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3:    return 16'(int'($urandom_range(0, 128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // Angles stay within a half turn most of the time; now and then any 13-bit code.
    function automatic logic signed [12:0] pick_angle();
        if ($urandom_range(0, 7) == 0) return 13'($urandom);
        return 13'(int'($urandom_range(0, 5759)) - 2880);
    endfunction

    function automatic t_tick rand_tick();
        t_tick tk;
        int    sel;
        tk.roll_angle       = pick_angle();
        tk.pitch_rate       = pick_wide();
        tk.yaw_angle        = pick_angle();
        tk.heading_target   = pick_angle();
        tk.turn_rate_target = pick_wide();
        tk.fwd_demand       = pick_wide();
        tk.wheel_speed_sum  = pick_wide();
        tk.run_enable       = ($urandom_range(0, 9) != 0);
        sel = $urandom_range(0, 9);
        if (sel < 4)       tk.turn_mode = TURN_RATE;
        else if (sel < 8)  tk.turn_mode = TURN_HEADING;
        else if (sel == 8) tk.turn_mode = TURN_HOLD;
        else               tk.turn_mode = TURN_SPARE;
        return tk;
    endfunction

    function automatic void plan_tick(input int roll, input int pitch, input int yaw,
                                      input int head, input int tspd, input logic [1:0] mode,
                                      input int fwd, input int wheel, input bit run,
                                      input bit typed, input int left, input int right);
        t_tick_row row;
        row.tk.roll_angle       = 13'(roll);
        row.tk.pitch_rate       = 16'(pitch);
        row.tk.yaw_angle        = 13'(yaw);
        row.tk.heading_target   = 13'(head);
        row.tk.turn_rate_target = 16'(tspd);
        row.tk.turn_mode        = mode;
        row.tk.fwd_demand       = 16'(fwd);
        row.tk.wheel_speed_sum  = 16'(wheel);
        row.tk.run_enable       = run;
        row.typed               = typed;
        row.left                = 16'(left);
        row.right               = 16'(right);
        plan.push_back(row);
    endfunction

    // Presents one tick, waits until it is taken, then records the drives it should give.
    task automatic issue_tick(input t_tick tk, input bit typed,
                              input logic signed [15:0] typed_left,
                              input logic signed [15:0] typed_right);
        t_drive_pair want;
        i_valid            <= 1'b1;
        i_roll_angle       <= tk.roll_angle;
        i_pitch_rate       <= tk.pitch_rate;
        i_yaw_angle        <= tk.yaw_angle;
        i_heading_target   <= tk.heading_target;
        i_turn_rate_target <= tk.turn_rate_target;
        i_turn_mode        <= tk.turn_mode;
        i_fwd_demand       <= tk.fwd_demand;
        i_wheel_speed_sum  <= tk.wheel_speed_sum;
        i_run_enable       <= tk.run_enable;
        do @(posedge i_clk); while (o_stall);
        mixer_predict(tk, want.left, want.right);
        if (typed) begin
            want.left = typed_left;
            want.right = typed_right;
        end
        drives_due.push_back(want);
        n_ticks++;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // A quarter of the bursts are long, so the pipeline also runs flat out.
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 80);
            else burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Receiver back-pressure: a new style each time the stall counter wraps.
    logic [5:0]   stall_cnt = '0;
    t_stall_style stall_style = STALL_NONE;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cnt   <= '0;
            stall_style <= STALL_NONE;
            i_stall     <= 1'b0;
        end else begin
            stall_cnt <= stall_cnt + 6'd1;
            if (stall_cnt == '0) stall_style <= t_stall_style'($urandom_range(0, 3));
            case (stall_style)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= (stall_cnt[1:0] == 2'b01);
            endcase
        end
    end

    always @(posedge i_clk) begin : drive_check
        t_drive_pair want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_drives++;
            if (drives_due.size() == 0) begin
                report_miss($sformatf("drives L=%0d R=%0d with no tick outstanding",
                                      o_left_drive, o_right_drive));
            end else begin
                want = drives_due.pop_front();
                if (o_left_drive !== want.left)
                    report_miss($sformatf("left drive %0d, expected %0d",
                                          o_left_drive, want.left));
                if (o_right_drive !== want.right)
                    report_miss($sformatf("right drive %0d, expected %0d",
                                          o_right_drive, want.right));
            end
        end
    end

    initial begin
        #2000000;
        $display("** balance_robot_motor_mixer: FAILED **");
        $finish;
    end

    initial begin
        // Rows: roll, pitch rate, yaw, heading target, turn rate, mode, forward demand,
        // wheel sum, run, typed, left, right.
        plan_tick(-96, 53, 0, 0, 0, TURN_HOLD, 0, 0, 1, 1, 0, 0);
        plan_tick(2880, -32768, 2879, -2880, 32767, TURN_RATE, 32767, -32768, 0, 1, 0, 0);
        plan_tick(2880, 0, 0, 0, 0, TURN_HOLD, 0, 0, 1, 0, 0, 0);
        plan_tick(-2880, 0, 0, 0, 0, TURN_HOLD, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 32767, 0, 0, 0, TURN_HOLD, 0, 0, 1, 0, 0, 0);
        plan_tick(0, -32768, 0, 0, 0, TURN_HOLD, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 0, 0, 32767, TURN_RATE, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 0, 0, -32768, TURN_RATE, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 0, 0, 3, TURN_RATE, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 100, -50, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        // Heading errors either side of the half-turn and full-turn boundaries.
        plan_tick(0, 0, -2880, 2879, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, -2880, 1, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, -2880, 0, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 2879, -1, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 2879, -2880, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 4095, -4096, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, -4096, 1665, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 2880, 0, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, -2880, 2880, 0, TURN_HEADING, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 0, 0, 1000, TURN_HOLD, 0, 0, 1, 0, 0, 0);
        // The twentieth running tick fires the speed loop with the widest error.
        plan_tick(0, 0, 0, 0, -1000, TURN_SPARE, 32767, -32768, 1, 0, 0, 0);
        plan_tick(-2880, 32767, 0, 0, -32768, TURN_RATE, 0, 0, 1, 0, 0, 0);
        plan_tick(2880, -32768, 0, 0, 32767, TURN_RATE, 0, 0, 1, 0, 0, 0);
        plan_tick(0, 0, 0, 0, 0, TURN_HOLD, 0, 0, 0, 1, 0, 0);
        n_directed = plan.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) issue_tick(plan[k].tk, plan[k].typed, plan[k].left, plan[k].right);
        i_valid <= 1'b0;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            while (drives_due.size() != 0) @(posedge i_clk);
            case (ph)
                0: ;
                1: load_gains(32767, 32767, 32767, 32767, 32767, 32767, 2880, 32767);
                2: load_gains(-32768, -32768, -32768, -32768, -32768, -32768, -2880, -32768);
                3: load_gains(0, 0, 0, 0, 0, 0, 0, 0);
                7: load_gains(RST_VEL_PGAIN, RST_VEL_IGAIN, RST_HEADING_KP, RST_TURN_KP,
                              RST_TILT_KP, RST_TILT_KD, RST_CENTRE, RST_GYRO_BIAS);
                default: load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                                    rand_gain(), rand_gain(),
                                    int'($urandom_range(0, 5760)) - 2880, rand_gain());
            endcase
            repeat (TICKS_PER_PHASE) issue_tick(rand_tick(), 1'b0, 16'sd0, 16'sd0);
            i_valid <= 1'b0;
        end

        while (drives_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d ticks (%0d directed) over %0d gain settings, checked %0d drive pairs.",
                 n_ticks, n_directed, N_PHASES, n_drives);
        $display("The speed loop ran %0d times; %0d mismatches seen.", n_speed_runs, n_errors);
        if (n_errors == 0) begin
            $display("** balance_robot_motor_mixer: PASSED **");
        end else begin
            $display("** balance_robot_motor_mixer: FAILED **");
        end
        $finish;
    end

endmodule
